@@ sv/itos_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itos_pkg
// Shared types, codes and helpers of the interval tree overlap search block.
// ----------------------------------------------------------------------------
package itos_pkg;

  // Width of a table offset or a node size (holds 0..64).
  localparam int unsigned IDXW       = 7;
  // Entries of the walk stack; the post-order fill needs about twice the
  // tree height, a query never more than STACK_DEPTH.
  localparam int unsigned FILL_DEPTH = 16;
  localparam int unsigned STW        = 4;
  localparam int unsigned SPW        = 5;
  localparam int unsigned VW         = 32;
  localparam int unsigned POSW       = 6;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_BUILD = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    OP_IDLE, OP_BI, OP_BKEY, OP_BJ, OP_BCMP, OP_FPEEK, OP_FRD, OP_FM1, OP_FM2,
    OP_QPOP, OP_QRD, OP_QCHK, OP_QLEFT, OP_QHIT, OP_QEND, OP_RESP
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_BI, S_BKEY, S_BJ, S_BCMP, S_FPEEK, S_FRD, S_FM1, S_FM2,
    S_QPOP, S_QRD, S_QCHK, S_QLEFT, S_QHIT, S_QEND, S_RESP
  } state_e;

  typedef struct packed {
    logic            expd;
    logic [IDXW-1:0] off;
    logic [IDXW-1:0] cnt;
  } stk_t;

  typedef struct packed {
    logic [IDXW-1:0] at;
    logic [IDXW-1:0] lr;
    logic [IDXW-1:0] rr;
    logic            has_l;
    logic            has_r;
    logic [IDXW-1:0] loff;
    logic [IDXW-1:0] lcnt;
    logic [IDXW-1:0] roff;
    logic [IDXW-1:0] rcnt;
  } geo_t;

  typedef struct packed {
    op_e  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic built;
    logic cnt_zero;
    logic i_done;
    logic j_zero;
    logic gt;
    logic sp_zero;
    logic top_exp;
    logic top_cnt_zero;
    logic hit;
    logic pend_v;
    logic out_free;
  } sts_t;

  // Root and child spans of a node that covers cnt sorted entries from off.
  function automatic geo_t node_geo(input logic [IDXW-1:0] off,
                                    input logic [IDXW-1:0] cnt);
    geo_t            g;
    logic [IDXW-1:0] x;
    x       = cnt >> 1;
    g.at    = off + x;
    g.has_l = (x != '0);
    g.has_r = ((x + IDXW'(1)) < cnt);
    g.loff  = off;
    g.lcnt  = x;
    g.lr    = off + (x >> 1);
    g.roff  = off + x + IDXW'(1);
    g.rcnt  = cnt - x - IDXW'(1);
    g.rr    = g.roff + (g.rcnt >> 1);
    return g;
  endfunction

endpackage
`default_nettype wire

@@ sv/itos_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itos_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itos_ram #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/itos_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itos_dp
// Datapath: interval and subtree-max memories, sort and walk registers,
// walk stack, pending hit and the output word register.
// ----------------------------------------------------------------------------
module itos_dp #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned STACK_DEPTH = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire itos_pkg::cmd_t                  cmd_i,
  input  wire logic [1:0]                      in_kind_i,
  input  wire logic [itos_pkg::VW-1:0]         in_lo_i,
  input  wire logic [itos_pkg::VW-1:0]         in_hi_i,
  input  wire logic                            out_ready_i,
  output itos_pkg::sts_t                       sts_o,
  output logic                                 out_valid_o,
  output logic [1:0]                           out_status_o,
  output logic                                 out_found_o,
  output logic [itos_pkg::POSW-1:0]            out_pos_o,
  output logic [itos_pkg::VW-1:0]              out_lo_o,
  output logic [itos_pkg::VW-1:0]              out_hi_o,
  output logic                                 out_last_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned IDXW = itos_pkg::IDXW;
  localparam int unsigned SPW  = itos_pkg::SPW;
  localparam int unsigned STW  = itos_pkg::STW;
  localparam int unsigned VW   = itos_pkg::VW;
  localparam int unsigned POSW = itos_pkg::POSW;

  // Control state.
  logic [IDXW-1:0] cnt_q, cnt_d;
  logic            built_q, built_d;
  logic [SPW-1:0]  sp_q, sp_d;
  logic            ov_q, ov_d;
  logic            pend_v_q, pend_v_d;

  // Payload state.
  logic [VW-1:0]        qlo_q, qlo_d, qhi_q, qhi_d;
  logic [1:0]           resp_q, resp_d;
  logic [IDXW-1:0]      i_q, i_d, j_q, j_d;
  logic [2*VW-1:0]      key_q, key_d;
  itos_pkg::stk_t       stk_q [itos_pkg::FILL_DEPTH];
  itos_pkg::stk_t       stk_d [itos_pkg::FILL_DEPTH];
  logic [IDXW-1:0]      noff_q, noff_d, ncnt_q, ncnt_d;
  logic [VW-1:0]        max_q, max_d;
  logic                 hit_q, hit_d;
  logic [POSW-1:0]      cpos_q, cpos_d, ppos_q, ppos_d;
  logic [VW-1:0]        clo_q, clo_d, chi_q, chi_d, plo_q, plo_d, phi_q, phi_d;
  logic [1:0]           os_q, os_d;
  logic                 of_q, of_d, ol_q, ol_d;
  logic [POSW-1:0]      op_q, op_d;
  logic [VW-1:0]        olo_q, olo_d, ohi_q, ohi_d;

  // Memory ports.
  logic            pwe, swe;
  logic [AW-1:0]   pwaddr, praddr, swaddr, sraddr;
  logic [2*VW-1:0] pwdata, prd;
  logic [VW-1:0]   swdata, srd;

  logic [SPW-1:0]  sp_m1, k;
  logic [STW-1:0]  tix;
  itos_pkg::stk_t  top;
  itos_pkg::geo_t  ng, tg;
  logic            out_free;
  logic [VW-1:0]   rlo, rhi, m;

  itos_ram #(.W(2*VW), .DEPTH(CAPACITY)) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (pwe),
    .waddr_i(pwaddr),
    .wdata_i(pwdata),
    .raddr_i(praddr),
    .rdata_o(prd)
  );

  itos_ram #(.W(VW), .DEPTH(CAPACITY)) u_max_ram (
    .clk_i  (clk_i),
    .we_i   (swe),
    .waddr_i(swaddr),
    .wdata_i(swdata),
    .raddr_i(sraddr),
    .rdata_o(srd)
  );

  assign sp_m1    = sp_q - SPW'(1);
  assign tix      = sp_m1[STW-1:0];
  assign top      = stk_q[tix];
  assign ng       = itos_pkg::node_geo(noff_q, ncnt_q);
  assign tg       = itos_pkg::node_geo(top.off, top.cnt);
  assign out_free = !ov_q || out_ready_i;
  assign rlo      = prd[VW-1:0];
  assign rhi      = prd[2*VW-1:VW];

  always_comb begin
    sts_o.built        = built_q;
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.i_done       = (i_q >= cnt_q);
    sts_o.j_zero       = (j_q == '0);
    sts_o.gt           = ($signed(rlo) > $signed(key_q[VW-1:0]));
    sts_o.sp_zero      = (sp_q == '0);
    sts_o.top_exp      = top.expd;
    sts_o.top_cnt_zero = (top.cnt == '0);
    sts_o.hit          = hit_q;
    sts_o.pend_v       = pend_v_q;
    sts_o.out_free     = out_free;
  end

  always_comb begin
    cnt_d = cnt_q;   built_d = built_q; sp_d = sp_q;   pend_v_d = pend_v_q;
    qlo_d = qlo_q;   qhi_d = qhi_q;     resp_d = resp_q;
    i_d = i_q;       j_d = j_q;         key_d = key_q;
    stk_d = stk_q;   noff_d = noff_q;   ncnt_d = ncnt_q; max_d = max_q;
    hit_d = hit_q;   cpos_d = cpos_q;   clo_d = clo_q;   chi_d = chi_q;
    ppos_d = ppos_q; plo_d = plo_q;     phi_d = phi_q;
    os_d = os_q;     of_d = of_q;       ol_d = ol_q;
    op_d = op_q;     olo_d = olo_q;     ohi_d = ohi_q;
    ov_d = ov_q && !out_ready_i;
    pwe = 1'b0; pwaddr = '0; pwdata = '0; praddr = '0;
    swe = 1'b0; swaddr = '0; swdata = '0; sraddr = '0;
    k = sp_q;
    m = max_q;

    unique case (cmd_i.op)
      itos_pkg::OP_IDLE: begin
        if (cmd_i.accept) begin
          qlo_d  = in_lo_i;
          qhi_d  = in_hi_i;
          resp_d = itos_pkg::STAT_OK;
          unique case (itos_pkg::kind_e'(in_kind_i))
            itos_pkg::KIND_LOAD: begin
              if (cnt_q < IDXW'(CAPACITY)) begin
                pwe     = 1'b1;
                pwaddr  = cnt_q[AW-1:0];
                pwdata  = {in_hi_i, in_lo_i};
                cnt_d   = cnt_q + IDXW'(1);
                built_d = 1'b0;
              end else begin
                resp_d = itos_pkg::STAT_FULL;
              end
            end
            itos_pkg::KIND_BUILD: i_d = IDXW'(1);
            itos_pkg::KIND_QUERY: begin
              if (!built_q) begin
                resp_d = itos_pkg::STAT_NO_BUILD;
              end else begin
                sp_d     = (cnt_q != '0) ? SPW'(1) : '0;
                stk_d[0] = '{expd: 1'b0, off: '0, cnt: cnt_q};
                pend_v_d = 1'b0;
              end
            end
            itos_pkg::KIND_CLEAR: begin
              cnt_d   = '0;
              built_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      itos_pkg::OP_BI: begin
        if (i_q >= cnt_q) begin
          if (cnt_q != '0) begin
            sp_d     = SPW'(1);
            stk_d[0] = '{expd: 1'b0, off: '0, cnt: cnt_q};
          end else begin
            built_d = 1'b1;
          end
        end else begin
          praddr = i_q[AW-1:0];
        end
      end
      itos_pkg::OP_BKEY: begin
        key_d = prd;
        j_d   = i_q;
      end
      itos_pkg::OP_BJ: begin
        if (j_q == '0) begin
          pwe    = 1'b1;
          pwaddr = '0;
          pwdata = key_q;
          i_d    = i_q + IDXW'(1);
        end else begin
          praddr = AW'(j_q - IDXW'(1));
        end
      end
      itos_pkg::OP_BCMP: begin
        pwe    = 1'b1;
        pwaddr = j_q[AW-1:0];
        if ($signed(rlo) > $signed(key_q[VW-1:0])) begin
          pwdata = prd;
          j_d    = j_q - IDXW'(1);
        end else begin
          pwdata = key_q;
          i_d    = i_q + IDXW'(1);
        end
      end
      itos_pkg::OP_FPEEK: begin
        if (!top.expd) begin
          stk_d[tix].expd = 1'b1;
          if (tg.has_r) begin
            stk_d[k[STW-1:0]] = '{expd: 1'b0, off: tg.roff, cnt: tg.rcnt};
            k = k + SPW'(1);
          end
          if (tg.has_l) begin
            stk_d[k[STW-1:0]] = '{expd: 1'b0, off: tg.loff, cnt: tg.lcnt};
            k = k + SPW'(1);
          end
          sp_d = k;
        end else begin
          sp_d   = sp_m1;
          noff_d = top.off;
          ncnt_d = top.cnt;
        end
      end
      itos_pkg::OP_FRD: begin
        praddr = ng.at[AW-1:0];
        sraddr = ng.lr[AW-1:0];
      end
      itos_pkg::OP_FM1: begin
        max_d  = (ng.has_l && ($signed(srd) > $signed(rhi))) ? srd : rhi;
        sraddr = ng.rr[AW-1:0];
      end
      itos_pkg::OP_FM2: begin
        if (ng.has_r && ($signed(srd) > $signed(max_q))) begin
          m = srd;
        end
        swe    = 1'b1;
        swaddr = ng.at[AW-1:0];
        swdata = m;
        if (sp_q == '0) begin
          built_d = 1'b1;
        end
      end
      itos_pkg::OP_QPOP: begin
        if (sp_q != '0) begin
          sp_d   = sp_m1;
          noff_d = top.off;
          ncnt_d = top.cnt;
        end
      end
      itos_pkg::OP_QRD: begin
        praddr = ng.at[AW-1:0];
        sraddr = ng.rr[AW-1:0];
      end
      itos_pkg::OP_QCHK: begin
        hit_d  = ($signed(rlo) <= $signed(qhi_q)) && ($signed(qlo_q) <= $signed(rhi));
        cpos_d = ng.at[POSW-1:0];
        clo_d  = rlo;
        chi_d  = rhi;
        sraddr = ng.lr[AW-1:0];
        if (ng.has_r && ($signed(rlo) <= $signed(qhi_q)) &&
            ($signed(srd) >= $signed(qlo_q)) && (sp_q < SPW'(STACK_DEPTH))) begin
          stk_d[sp_q[STW-1:0]] = '{expd: 1'b0, off: ng.roff, cnt: ng.rcnt};
          sp_d = sp_q + SPW'(1);
        end
      end
      itos_pkg::OP_QLEFT: begin
        if (ng.has_l && ($signed(srd) >= $signed(qlo_q)) &&
            (sp_q < SPW'(STACK_DEPTH))) begin
          stk_d[sp_q[STW-1:0]] = '{expd: 1'b0, off: ng.loff, cnt: ng.lcnt};
          sp_d = sp_q + SPW'(1);
        end
      end
      itos_pkg::OP_QHIT: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            ov_d  = 1'b1;
            os_d  = itos_pkg::STAT_OK;
            of_d  = 1'b1;
            op_d  = ppos_q;
            olo_d = plo_q;
            ohi_d = phi_q;
            ol_d  = 1'b0;
          end
          pend_v_d = 1'b1;
          ppos_d   = cpos_q;
          plo_d    = clo_q;
          phi_d    = chi_q;
        end
      end
      itos_pkg::OP_QEND: begin
        if (out_free) begin
          ov_d     = 1'b1;
          os_d     = itos_pkg::STAT_OK;
          of_d     = pend_v_q;
          op_d     = pend_v_q ? ppos_q : '0;
          olo_d    = pend_v_q ? plo_q : '0;
          ohi_d    = pend_v_q ? phi_q : '0;
          ol_d     = 1'b1;
          pend_v_d = 1'b0;
        end
      end
      itos_pkg::OP_RESP: begin
        if (out_free) begin
          ov_d  = 1'b1;
          os_d  = resp_q;
          of_d  = 1'b0;
          op_d  = '0;
          olo_d = '0;
          ohi_d = '0;
          ol_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      built_q  <= 1'b0;
      sp_q     <= '0;
      ov_q     <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      built_q  <= built_d;
      sp_q     <= sp_d;
      ov_q     <= ov_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qlo_q <= qlo_d;   qhi_q <= qhi_d;   resp_q <= resp_d;
    i_q <= i_d;       j_q <= j_d;       key_q <= key_d;
    stk_q <= stk_d;   noff_q <= noff_d; ncnt_q <= ncnt_d; max_q <= max_d;
    hit_q <= hit_d;   cpos_q <= cpos_d; clo_q <= clo_d;   chi_q <= chi_d;
    ppos_q <= ppos_d; plo_q <= plo_d;   phi_q <= phi_d;
    os_q <= os_d;     of_q <= of_d;     ol_q <= ol_d;
    op_q <= op_d;     olo_q <= olo_d;   ohi_q <= ohi_d;
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = os_q;
  assign out_found_o  = of_q;
  assign out_pos_o    = op_q;
  assign out_lo_o     = olo_q;
  assign out_hi_o     = ohi_q;
  assign out_last_o   = ol_q;

endmodule
`default_nettype wire

@@ sv/itos_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itos_ctrl
// Controller: sequences load, sort, subtree-max fill and tree walk.
// ----------------------------------------------------------------------------
module itos_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     in_kind_i,
  input  wire itos_pkg::sts_t sts_i,
  output logic                in_ready_o,
  output itos_pkg::cmd_t      cmd_o
);

  itos_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_ready_o = (state_q == itos_pkg::S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itos_pkg::S_IDLE: begin
        if (accept) begin
          unique case (itos_pkg::kind_e'(in_kind_i))
            itos_pkg::KIND_BUILD: state_d = itos_pkg::S_BI;
            itos_pkg::KIND_QUERY: state_d = sts_i.built ? itos_pkg::S_QPOP
                                                        : itos_pkg::S_RESP;
            default:              state_d = itos_pkg::S_RESP;
          endcase
        end
      end
      itos_pkg::S_BI: begin
        if (sts_i.i_done) begin
          state_d = sts_i.cnt_zero ? itos_pkg::S_RESP : itos_pkg::S_FPEEK;
        end else begin
          state_d = itos_pkg::S_BKEY;
        end
      end
      itos_pkg::S_BKEY:  state_d = itos_pkg::S_BJ;
      itos_pkg::S_BJ:    state_d = sts_i.j_zero ? itos_pkg::S_BI : itos_pkg::S_BCMP;
      itos_pkg::S_BCMP:  state_d = sts_i.gt ? itos_pkg::S_BJ : itos_pkg::S_BI;
      itos_pkg::S_FPEEK: state_d = sts_i.top_exp ? itos_pkg::S_FRD : itos_pkg::S_FPEEK;
      itos_pkg::S_FRD:   state_d = itos_pkg::S_FM1;
      itos_pkg::S_FM1:   state_d = itos_pkg::S_FM2;
      itos_pkg::S_FM2:   state_d = sts_i.sp_zero ? itos_pkg::S_RESP : itos_pkg::S_FPEEK;
      itos_pkg::S_QPOP: begin
        priority if (sts_i.sp_zero) begin
          state_d = itos_pkg::S_QEND;
        end else if (sts_i.top_cnt_zero) begin
          state_d = itos_pkg::S_QPOP;
        end else begin
          state_d = itos_pkg::S_QRD;
        end
      end
      itos_pkg::S_QRD:   state_d = itos_pkg::S_QCHK;
      itos_pkg::S_QCHK:  state_d = itos_pkg::S_QLEFT;
      itos_pkg::S_QLEFT: state_d = sts_i.hit ? itos_pkg::S_QHIT : itos_pkg::S_QPOP;
      itos_pkg::S_QHIT: begin
        if (!sts_i.pend_v || sts_i.out_free) begin
          state_d = itos_pkg::S_QPOP;
        end
      end
      itos_pkg::S_QEND, itos_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          state_d = itos_pkg::S_IDLE;
        end
      end
      default: state_d = itos_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.accept = accept;
    unique case (state_q)
      itos_pkg::S_IDLE:  cmd_o.op = itos_pkg::OP_IDLE;
      itos_pkg::S_BI:    cmd_o.op = itos_pkg::OP_BI;
      itos_pkg::S_BKEY:  cmd_o.op = itos_pkg::OP_BKEY;
      itos_pkg::S_BJ:    cmd_o.op = itos_pkg::OP_BJ;
      itos_pkg::S_BCMP:  cmd_o.op = itos_pkg::OP_BCMP;
      itos_pkg::S_FPEEK: cmd_o.op = itos_pkg::OP_FPEEK;
      itos_pkg::S_FRD:   cmd_o.op = itos_pkg::OP_FRD;
      itos_pkg::S_FM1:   cmd_o.op = itos_pkg::OP_FM1;
      itos_pkg::S_FM2:   cmd_o.op = itos_pkg::OP_FM2;
      itos_pkg::S_QPOP:  cmd_o.op = itos_pkg::OP_QPOP;
      itos_pkg::S_QRD:   cmd_o.op = itos_pkg::OP_QRD;
      itos_pkg::S_QCHK:  cmd_o.op = itos_pkg::OP_QCHK;
      itos_pkg::S_QLEFT: cmd_o.op = itos_pkg::OP_QLEFT;
      itos_pkg::S_QHIT:  cmd_o.op = itos_pkg::OP_QHIT;
      itos_pkg::S_QEND:  cmd_o.op = itos_pkg::OP_QEND;
      itos_pkg::S_RESP:  cmd_o.op = itos_pkg::OP_RESP;
      default:           cmd_o.op = itos_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itos_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/interval_tree_overlap_search.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// interval_tree_overlap_search
// Interval store with a sorted implicit tree and an overlap query walk.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata                               tuser             tlast
//  s_axis    in   [31:0] low_end, [63:32] high_end    [1:0] kind        -
//  m_axis    out  [5:0] position, [37:6] hit_low,     [1:0] status,     last
//                 [69:38] hit_high                    [2] found
//
// The block takes one word at a time. Load and clear go from idle to the
// response state, which registers the result. A build runs an insertion
// sort over the memory (S_BJ reads, S_BCMP compares), then a post-order
// fill of the subtree maxima (S_FPEEK, S_FRD, S_FM1, S_FM2). A query walks
// each visited node through S_QPOP, S_QRD, S_QCHK, S_QLEFT, S_QHIT on a hit;
// its two subtree-max reads share the single read port of that memory.
// A stalled result holds the block in place; the next word is taken once
// the final result has entered the output register.
// Reset clears the entry count, the built flag and all handshake state.
// ----------------------------------------------------------------------------
module interval_tree_overlap_search #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned STACK_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // [31:0] low_end, [63:32] high_end
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] kind
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,  // [5:0] position, [37:6] hit_low,
                                            // [69:38] hit_high, [71:70] zero
  output logic [2:0]       m_axis_tuser_o,  // [1:0] status, [2] found
  output logic             m_axis_tlast_o
);

  itos_pkg::cmd_t              cmd;
  itos_pkg::sts_t              sts;
  logic [1:0]                  status;
  logic                        found;
  logic [itos_pkg::POSW-1:0]   pos;
  logic [itos_pkg::VW-1:0]     hit_lo, hit_hi;

  // The controller only steps through states; all storage sits in the datapath.
  itos_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_kind_i (s_axis_tuser_i),
    .sts_i     (sts),
    .in_ready_o(s_axis_tready_o),
    .cmd_o     (cmd)
  );

  itos_dp #(.CAPACITY(CAPACITY), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_kind_i   (s_axis_tuser_i),
    .in_lo_i     (s_axis_tdata_i[31:0]),
    .in_hi_i     (s_axis_tdata_i[63:32]),
    .out_ready_i (m_axis_tready_i),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_status_o(status),
    .out_found_o (found),
    .out_pos_o   (pos),
    .out_lo_o    (hit_lo),
    .out_hi_o    (hit_hi),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, hit_hi, hit_lo, pos};
  assign m_axis_tuser_o = {found, status};

endmodule
`default_nettype wire

@@ sv/itos_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itos_chk
// Port-level checker for the interval tree overlap search block.
// ----------------------------------------------------------------------------
module itos_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [71:0] m_axis_tdata_o,
  input wire logic [2:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // An accepted word starts work, so the input side closes next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again while busy");

  // Error results are single, final and carry no interval.
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] != 2'd0) |->
      m_axis_tlast_o && !m_axis_tuser_o[2] && (m_axis_tuser_o[1:0] != 2'd3))
    else $error("malformed error result");

  // A result without a hit is final and all zero.
  a_miss_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[2] |->
      m_axis_tlast_o && (m_axis_tdata_o == 72'd0))
    else $error("malformed non-hit result");

endmodule

bind interval_tree_overlap_search itos_chk u_itos_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
`default_nettype wire

@@ tb/tb_interval_tree_overlap_search.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_interval_tree_overlap_search
// Self-checking bench for the interval store and its overlap query walk.
// ----------------------------------------------------------------------------
// Each word sent on the slave stream is also applied to a behavioral model of
// the store: a load table, a stable sort with subtree maxima, and a pre-order
// walk. The words the model expects are queued and every word leaving the
// master stream is compared field by field with the oldest one. The random
// part is mostly well-formed load, build and query sequences over a small
// value range, so that overlaps, ties and a full table are common.
// ----------------------------------------------------------------------------
module tb_interval_tree_overlap_search;

  localparam int unsigned CAP = 64;

  typedef struct packed {
    itos_pkg::stat_e status;
    logic            found;
    logic [5:0]      position;
    logic [31:0]     hit_low;
    logic [31:0]     hit_high;
    logic            last;
  } hit_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  interval_tree_overlap_search dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state.
  logic signed [31:0] lefts[CAP];
  logic signed [31:0] rights[CAP];
  logic signed [31:0] sub_max[CAP];
  int                 n_entries;
  bit                 built;

  hit_word_t expected_words[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic signed [31:0] fill_subtree(input int off, input int cnt);
    int                 med;
    logic signed [31:0] m;
    logic signed [31:0] t;
    med = cnt / 2;
    m = rights[off + med];
    if (med > 0) begin
      t = fill_subtree(off, med);
      if (t > m) m = t;
    end
    if (med + 1 < cnt) begin
      t = fill_subtree(off + med + 1, cnt - med - 1);
      if (t > m) m = t;
    end
    sub_max[off + med] = m;
    return m;
  endfunction

  function automatic hit_word_t plain_word(input itos_pkg::stat_e st);
    hit_word_t w;
    w = '0;
    w.status = st;
    w.last = 1'b1;
    return w;
  endfunction

  // Applies one input word to the model and queues what it must answer.
  task automatic predict_overlaps(input itos_pkg::kind_e k, input logic signed [31:0] lo,
                                  input logic signed [31:0] hi);
    int                 offs[$];
    int                 cnts[$];
    int                 off;
    int                 cnt;
    int                 x;
    int                 at;
    int                 rc;
    int                 hits;
    logic signed [31:0] kl;
    logic signed [31:0] kr;
    int                 j;
    hit_word_t          w;
    case (k)
      itos_pkg::KIND_LOAD: begin
        if (n_entries >= CAP) begin
          expected_words.push_back(plain_word(itos_pkg::STAT_FULL));
        end else begin
          lefts[n_entries] = lo;
          rights[n_entries] = hi;
          n_entries++;
          built = 0;
          expected_words.push_back(plain_word(itos_pkg::STAT_OK));
        end
      end
      itos_pkg::KIND_BUILD: begin
        for (int i = 1; i < n_entries; i++) begin
          kl = lefts[i];
          kr = rights[i];
          j = i;
          while (j > 0 && lefts[j-1] > kl) begin
            lefts[j] = lefts[j-1];
            rights[j] = rights[j-1];
            j--;
          end
          lefts[j] = kl;
          rights[j] = kr;
        end
        if (n_entries > 0) void'(fill_subtree(0, n_entries));
        built = 1;
        expected_words.push_back(plain_word(itos_pkg::STAT_OK));
      end
      itos_pkg::KIND_QUERY: begin
        if (!built) begin
          expected_words.push_back(plain_word(itos_pkg::STAT_NO_BUILD));
        end else begin
          hits = 0;
          if (n_entries > 0) begin
            offs.push_back(0);
            cnts.push_back(n_entries);
          end
          // The stack never overflows at this capacity, so it is unbounded here.
          while (offs.size() > 0) begin
            off = offs.pop_back();
            cnt = cnts.pop_back();
            if (cnt == 0) continue;
            x = cnt / 2;
            at = off + x;
            if (lefts[at] <= hi && lo <= rights[at]) begin
              w = '0;
              w.status = itos_pkg::STAT_OK;
              w.found = 1'b1;
              w.position = at[5:0];
              w.hit_low = lefts[at];
              w.hit_high = rights[at];
              expected_words.push_back(w);
              hits++;
            end
            // The right span goes on the stack first so the left one is walked first.
            if (x + 1 < cnt && lefts[at] <= hi) begin
              rc = cnt - x - 1;
              if (sub_max[off + x + 1 + rc / 2] >= lo) begin
                offs.push_back(off + x + 1);
                cnts.push_back(rc);
              end
            end
            if (x > 0 && sub_max[off + x / 2] >= lo) begin
              offs.push_back(off);
              cnts.push_back(x);
            end
          end
          if (hits == 0) expected_words.push_back(plain_word(itos_pkg::STAT_OK));
          else expected_words[$].last = 1'b1;
        end
      end
      default: begin
        n_entries = 0;
        built = 0;
        expected_words.push_back(plain_word(itos_pkg::STAT_OK));
      end
    endcase
  endtask

  // Sends one word, then predicts it once it has been taken. The valid line
  // stays up after the handshake and is dropped only when the sender idles.
  task automatic send_word(input itos_pkg::kind_e k, input logic signed [31:0] lo,
                           input logic signed [31:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= k;
    s_axis_tdata_i <= {hi, lo};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_overlaps(k, lo, hi);
  endtask

  // Receiver: random stalls and the comparison of each word taken.
  always @(posedge clk_i) begin
    hit_word_t got;
    hit_word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status = itos_pkg::stat_e'(m_axis_tuser_o[1:0]);
        got.found = m_axis_tuser_o[2];
        got.position = m_axis_tdata_o[5:0];
        got.hit_low = m_axis_tdata_o[37:6];
        got.hit_high = m_axis_tdata_o[69:38];
        got.last = m_axis_tlast_o;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %p", got));
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
          if (got.found !== want.found)
            report_mismatch($sformatf("found %0b want %0b", got.found, want.found));
          if (got.position !== want.position)
            report_mismatch($sformatf("position %0d want %0d", got.position,
                                      want.position));
          if (got.hit_low !== want.hit_low)
            report_mismatch($sformatf("hit_low %0d want %0d", $signed(got.hit_low),
                                      $signed(want.hit_low)));
          if (got.hit_high !== want.hit_high)
            report_mismatch($sformatf("hit_high %0d want %0d", $signed(got.hit_high),
                                      $signed(want.hit_high)));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0b want %0b", got.last, want.last));
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(80)) - 40;
    endcase
  endfunction

  task automatic test_directed();
    send_word(itos_pkg::KIND_QUERY, 0, 0);             // query before any build
    send_word(itos_pkg::KIND_BUILD, 0, 0);             // build of an empty table
    send_word(itos_pkg::KIND_QUERY, 32'sh8000_0000, 32'sh7fff_ffff);
    send_word(itos_pkg::KIND_LOAD, 32'sh8000_0000, 32'sh8000_0000);
    send_word(itos_pkg::KIND_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_word(itos_pkg::KIND_LOAD, 5, 10);
    send_word(itos_pkg::KIND_LOAD, 5, 7);              // tie on the left end
    send_word(itos_pkg::KIND_LOAD, 20, 3);             // reversed interval
    send_word(itos_pkg::KIND_LOAD, -1, 0);
    send_word(itos_pkg::KIND_QUERY, 0, 1);             // load after build clears it
    send_word(itos_pkg::KIND_BUILD, 0, 0);
    send_word(itos_pkg::KIND_QUERY, 32'sh8000_0000, 32'sh7fff_ffff);
    send_word(itos_pkg::KIND_QUERY, 10, 10);           // touches an end only
    send_word(itos_pkg::KIND_QUERY, 11, 19);           // no overlap
    send_word(itos_pkg::KIND_QUERY, 9, 2);             // reversed query
    send_word(itos_pkg::KIND_QUERY, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_word(itos_pkg::KIND_CLEAR, 32'sh7fff_ffff, 32'sh8000_0000);
    send_word(itos_pkg::KIND_QUERY, 0, 0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < CAP + 2; i++)
      send_word(itos_pkg::KIND_LOAD, pick_value(), pick_value());
    send_word(itos_pkg::KIND_BUILD, 0, 0);
    for (int i = 0; i < 4; i++) send_word(itos_pkg::KIND_QUERY, pick_value(), pick_value());
    send_word(itos_pkg::KIND_CLEAR, 0, 0);
  endtask

  task automatic test_random_sessions(input int words);
    int sent;
    int loads;
    logic signed [31:0] a;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(9) == 0) begin
        // Noise: any kind with any ends.
        send_word(itos_pkg::kind_e'($urandom_range(3)), $urandom, $urandom);
        sent++;
      end else begin
        send_word(itos_pkg::KIND_CLEAR, $urandom, $urandom);
        loads = ($urandom_range(7) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
        for (int i = 0; i < loads; i++) begin
          a = pick_value();
          send_word(itos_pkg::KIND_LOAD, a, ($urandom_range(5) == 0) ? pick_value()
                                                                     : a + $urandom_range(15));
        end
        if ($urandom_range(7) != 0) send_word(itos_pkg::KIND_BUILD, $urandom, $urandom);
        for (int i = 0; i < $urandom_range(2, 6); i++) begin
          a = pick_value();
          send_word(itos_pkg::KIND_QUERY, a, ($urandom_range(4) == 0) ? pick_value()
                                                                      : a + $urandom_range(20));
        end
        sent += loads + 8;
      end
    end
  endtask

  initial begin
    n_entries = 0;
    built = 0;
    error_count = 0;
    send_idle_pct = 7;
    recv_idle_pct = 63;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random_sessions(130);
    send_idle_pct = 63;
    recv_idle_pct = 7;
    test_random_sessions(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sessions(130);
    s_axis_tvalid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_interval_tree_overlap_search: clean");
    end else begin
      $display("tb_interval_tree_overlap_search: errors");
    end
    $finish;
  end

  // Builds of a full table dominate; this leaves a wide margin over them.
  initial begin
    #200_000_000;
    $display("tb_interval_tree_overlap_search: errors");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
sv/itos_pkg.sv
sv/itos_ram.sv
sv/itos_dp.sv
sv/itos_ctrl.sv
sv/interval_tree_overlap_search.sv
sv/itos_chk.sv
tb/tb_interval_tree_overlap_search.sv
